// ----- design/dstp_pkg.sv -----
`default_nettype none

package dstp_pkg;

    // Drive states as decoded from the status word.
    typedef enum logic [3:0] {
        ST_NOT_READY   = 4'd0,
        ST_SO_DISABLED = 4'd1,
        ST_READY       = 4'd2,
        ST_SWITCHED_ON = 4'd3,
        ST_ENABLED     = 4'd4,
        ST_QUICK_STOP  = 4'd5,
        ST_FAULT_REACT = 4'd6,
        ST_FAULT       = 4'd7,
        ST_UNKNOWN     = 4'd8
    } drive_state_t;

    // Goal command codes; the remaining code is meaningless.
    localparam logic [2:0] GOAL_SHUTDOWN    = 3'd0;
    localparam logic [2:0] GOAL_SWITCH_ON   = 3'd1;
    localparam logic [2:0] GOAL_ENABLE_OP   = 3'd2;
    localparam logic [2:0] GOAL_DISABLE_OP  = 3'd3;
    localparam logic [2:0] GOAL_DIS_VOLT    = 3'd4;
    localparam logic [2:0] GOAL_QUICK_STOP  = 3'd5;
    localparam logic [2:0] GOAL_FAULT_RESET = 3'd6;
    localparam logic [2:0] GOAL_UNUSED      = 3'd7;

    // Control words.
    localparam logic [7:0] CW_SHUTDOWN  = 8'h06;
    localparam logic [7:0] CW_SWITCH_ON = 8'h07;
    localparam logic [7:0] CW_ENABLE_OP = 8'h0F;
    localparam logic [7:0] CW_DIS_VOLT  = 8'h00;
    localparam logic [7:0] CW_QSTOP     = 8'h02;
    localparam logic [7:0] CW_FRESET    = 8'h80;

    // Status word masks and patterns.
    localparam logic [15:0] MASK_A       = 16'h006F;
    localparam logic [15:0] MASK_B       = 16'h004F;
    localparam logic [15:0] PAT_READY    = 16'h0021;
    localparam logic [15:0] PAT_SW_ON    = 16'h0023;
    localparam logic [15:0] PAT_ENABLED  = 16'h0027;
    localparam logic [15:0] PAT_QSTOP    = 16'h0007;
    localparam logic [15:0] PAT_NOT_RDY  = 16'h0000;
    localparam logic [15:0] PAT_SO_DIS   = 16'h0040;
    localparam logic [15:0] PAT_F_REACT  = 16'h000F;
    localparam logic [15:0] PAT_FAULT    = 16'h0008;

    localparam int unsigned DATA_IN_W  = 24;
    localparam int unsigned DATA_OUT_W = 24;

    // Input beat payload; the first field sits in the highest bits.
    typedef struct packed {
        logic [2:0]  goal_command;
        logic [15:0] drive_status;
    } item_t;

    // Result beat payload; the first field sits in the highest bits.
    typedef struct packed {
        logic         autonomous_wait;
        logic         step_supported;
        logic         goal_reached;
        drive_state_t expected_state;
        logic [7:0]   control_word;
        drive_state_t decoded_state;
    } result_t;

    function automatic drive_state_t decode_state(logic [15:0] sw);
        logic [15:0] a;
        logic [15:0] b;
        drive_state_t s;
        begin
            a = sw & MASK_A;
            b = sw & MASK_B;
            if (a == PAT_READY)        s = ST_READY;
            else if (a == PAT_SW_ON)   s = ST_SWITCHED_ON;
            else if (a == PAT_ENABLED) s = ST_ENABLED;
            else if (a == PAT_QSTOP)   s = ST_QUICK_STOP;
            else if (b == PAT_NOT_RDY) s = ST_NOT_READY;
            else if (b == PAT_SO_DIS)  s = ST_SO_DISABLED;
            else if (b == PAT_F_REACT) s = ST_FAULT_REACT;
            else if (b == PAT_FAULT)   s = ST_FAULT;
            else                       s = ST_UNKNOWN;
            return s;
        end
    endfunction

    function automatic result_t plan_step(drive_state_t s, logic [2:0] g);
        result_t r;
        begin
            r.decoded_state   = s;
            r.control_word    = 8'h00;
            r.expected_state  = ST_UNKNOWN;
            r.goal_reached    = 1'b0;
            r.step_supported  = 1'b0;
            r.autonomous_wait = 1'b0;
            if (s == ST_UNKNOWN || g > GOAL_FAULT_RESET)
            begin
                // Unsupported pair: keep the defaults.
            end
            else if (s == ST_NOT_READY)
            begin
                r.control_word    = CW_DIS_VOLT;
                r.expected_state  = ST_SO_DISABLED;
                r.step_supported  = 1'b1;
                r.autonomous_wait = 1'b1;
            end
            else if (s == ST_FAULT_REACT)
            begin
                r.control_word    = CW_DIS_VOLT;
                r.expected_state  = ST_FAULT;
                r.step_supported  = (g == GOAL_FAULT_RESET);
                r.autonomous_wait = 1'b1;
            end
            else
            begin
                case (g)
                    GOAL_SHUTDOWN:
                    begin
                        if (s inside {ST_READY, ST_SO_DISABLED, ST_SWITCHED_ON, ST_ENABLED})
                        begin
                            r.control_word   = CW_SHUTDOWN;
                            r.expected_state = ST_READY;
                            r.goal_reached   = (s == ST_READY);
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_QUICK_STOP)
                        begin
                            r.control_word   = CW_DIS_VOLT;
                            r.expected_state = ST_SO_DISABLED;
                            r.step_supported = 1'b1;
                        end
                    end
                    GOAL_SWITCH_ON:
                    begin
                        if (s inside {ST_SWITCHED_ON, ST_READY, ST_ENABLED})
                        begin
                            r.control_word   = CW_SWITCH_ON;
                            r.expected_state = ST_SWITCHED_ON;
                            r.goal_reached   = (s == ST_SWITCHED_ON);
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_SO_DISABLED)
                        begin
                            r.control_word   = CW_SHUTDOWN;
                            r.expected_state = ST_READY;
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_QUICK_STOP)
                        begin
                            r.control_word   = CW_DIS_VOLT;
                            r.expected_state = ST_SO_DISABLED;
                            r.step_supported = 1'b1;
                        end
                    end
                    GOAL_ENABLE_OP:
                    begin
                        if (s inside {ST_ENABLED, ST_SWITCHED_ON, ST_QUICK_STOP})
                        begin
                            r.control_word   = CW_ENABLE_OP;
                            r.expected_state = ST_ENABLED;
                            r.goal_reached   = (s == ST_ENABLED);
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_READY)
                        begin
                            r.control_word   = CW_SWITCH_ON;
                            r.expected_state = ST_SWITCHED_ON;
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_SO_DISABLED)
                        begin
                            r.control_word   = CW_SHUTDOWN;
                            r.expected_state = ST_READY;
                            r.step_supported = 1'b1;
                        end
                    end
                    GOAL_DISABLE_OP:
                    begin
                        if (s inside {ST_ENABLED, ST_SWITCHED_ON})
                        begin
                            r.control_word   = CW_SWITCH_ON;
                            r.expected_state = ST_SWITCHED_ON;
                            r.goal_reached   = (s == ST_SWITCHED_ON);
                            r.step_supported = 1'b1;
                        end
                        else if (s inside {ST_READY, ST_SO_DISABLED, ST_QUICK_STOP})
                        begin
                            // Already below operation enabled: hold the state.
                            r.control_word   = (s == ST_READY) ? CW_SHUTDOWN :
                                               (s == ST_QUICK_STOP) ? CW_QSTOP : CW_DIS_VOLT;
                            r.expected_state = s;
                            r.goal_reached   = 1'b1;
                            r.step_supported = 1'b1;
                        end
                    end
                    GOAL_DIS_VOLT:
                    begin
                        if (s inside {ST_SO_DISABLED, ST_READY, ST_SWITCHED_ON, ST_ENABLED,
                                      ST_QUICK_STOP})
                        begin
                            r.control_word   = CW_DIS_VOLT;
                            r.expected_state = ST_SO_DISABLED;
                            r.goal_reached   = (s == ST_SO_DISABLED);
                            r.step_supported = 1'b1;
                        end
                    end
                    GOAL_QUICK_STOP:
                    begin
                        if (s == ST_QUICK_STOP)
                        begin
                            r.control_word   = CW_QSTOP;
                            r.expected_state = s;
                            r.goal_reached   = 1'b1;
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_SO_DISABLED)
                        begin
                            r.control_word   = CW_DIS_VOLT;
                            r.expected_state = s;
                            r.goal_reached   = 1'b1;
                            r.step_supported = 1'b1;
                        end
                        else if (s inside {ST_READY, ST_SWITCHED_ON, ST_ENABLED})
                        begin
                            r.control_word   = CW_QSTOP;
                            r.expected_state = ST_QUICK_STOP;
                            r.step_supported = 1'b1;
                        end
                    end
                    GOAL_FAULT_RESET:
                    begin
                        if (s == ST_FAULT)
                        begin
                            r.control_word   = CW_FRESET;
                            r.expected_state = ST_SO_DISABLED;
                            r.step_supported = 1'b1;
                        end
                        else if (s == ST_SO_DISABLED)
                        begin
                            r.control_word   = CW_DIS_VOLT;
                            r.expected_state = ST_SO_DISABLED;
                            r.goal_reached   = 1'b1;
                            r.step_supported = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/drive_state_transition_planner_top.sv -----
// Drive state transition planner.
// Slave channel s_axis: one beat carries a raw drive status word and a goal
// command. Master channel m_axis: one beat per input beat, carrying the decoded
// drive state, the control word to send next, the state expected after it and
// three flags (goal reached, step supported, drive advancing on its own).
// Unsupported pairs give control word zero and clear goal and step flags; outside
// fault reaction also expected state unknown, no wait; decoded state always reported.
// Structure: an input register, the mask-and-match decode plus the step table
// as one level of logic, then the result register. An accepted beat is held in
// the input register, and its result is loaded into the result register and
// offered on m_axis from there. Throughput is one beat per cycle while m_axis
// is not stalled, set by the single pass through the decode and table logic.
// Both registers advance independently, so a new beat is taken while a finished
// result still waits. When the receiver stalls, the result register holds and
// the input register fills; s_axis_tready then drops until the result is taken.
// Reset clears both valid flags; no beat is offered until a new one arrives.
`default_nettype none

module drive_state_transition_planner_top
    import dstp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] drive_status, [18:16] goal_command, [23:19] zero
    input  wire logic [DATA_IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] decoded_state, [11:4] control_word, [15:12] expected_state,
    // [16] goal_reached, [17] step_supported, [18] autonomous_wait, [23:19] zero
    output logic [DATA_OUT_W-1:0]      m_axis_tdata
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    out_free;
    logic    in_load;
    logic    out_load;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign out_load      = in_valid_reg && out_free;

    always_comb
    begin
        in_valid_next  = in_load || (in_valid_reg && !out_free);
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
        result_next    = plan_step(decode_state(in_item_reg.drive_status),
                                   in_item_reg.goal_command);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(DATA_OUT_W - $bits(result_t)){1'b0}}, result_reg};

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    a_item_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_free |=> out_valid_reg)
        else $error("registered item did not reach the result register");

    a_unsupported_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.step_supported |->
            result_reg.control_word == CW_DIS_VOLT && result_reg.goal_reached == 1'b0)
        else $error("unsupported step carries a control word or reached flag");

    a_reached_is_supported: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.goal_reached |-> result_reg.step_supported)
        else $error("goal reached without a supported step");

    a_unknown_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.decoded_state == ST_UNKNOWN |->
            !result_reg.step_supported && !result_reg.autonomous_wait)
        else $error("unknown drive state produced a step");
`endif

endmodule

`default_nettype wire
